FILE: rtl/core/sla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sla_pkg;

    // Line buffer size: one slot is kept back, so a line holds CAPACITY-1 characters.
    localparam int CAPACITY   = 32;
    localparam int LINE_DEPTH = CAPACITY - 1;
    localparam int CNT_W      = $clog2(CAPACITY);
    localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int DATA_W     = 8;
    localparam int KIND_W     = 2;

    localparam logic [DATA_W-1:0] CHAR_CR = 8'h0D;
    localparam logic [DATA_W-1:0] CHAR_LF = 8'h0A;

    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ECHO,
        ST_DRAIN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load_echo;
        logic append;
        logic load_char;
        logic load_end;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic term;
        logic out_free;
        logic drain_done;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/core/sla_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sla_in_if;
    logic                         valid;
    logic                         ready;
    logic [sla_pkg::DATA_W-1:0]   rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sla_out_if;
    logic                         valid;
    logic                         ready;
    logic [sla_pkg::KIND_W-1:0]   kind;
    logic [sla_pkg::DATA_W-1:0]   data;
    logic                         last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sla_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sla_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sla_pkg::t_cmd              i_cmd,
    output sla_pkg::t_status                o_status,
    input  wire logic [sla_pkg::DATA_W-1:0] i_rx_byte,
    input  wire logic                       i_out_ready,
    output logic                            o_out_valid,
    output logic [sla_pkg::KIND_W-1:0]      o_out_kind,
    output logic [sla_pkg::DATA_W-1:0]      o_out_data,
    output logic                            o_out_last
);
    import sla_pkg::*;

    logic [DATA_W-1:0] r_line [LINE_DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_byte;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  n_fill;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  n_rd_idx;
    logic              r_out_valid;
    logic              n_out_valid;
    t_kind             r_kind;
    logic [DATA_W-1:0] r_data;
    logic              r_last;
    logic              term;
    logic              has_room;

    assign term     = (r_byte == CHAR_CR) || (r_byte == CHAR_LF);
    assign has_room = r_fill < CNT_W'(LINE_DEPTH);

    assign o_status.term       = term;
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.drain_done = (r_rd_idx == r_fill);

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.load_end) begin
            n_fill = '0;
        end else if (i_cmd.append && has_room) begin
            n_fill = r_fill + CNT_W'(1);
        end
    end

    always_comb begin
        n_rd_idx = r_rd_idx;
        if (i_cmd.load_end) begin
            n_rd_idx = '0;
        end else if (i_cmd.load_char) begin
            n_rd_idx = r_rd_idx + CNT_W'(1);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.load_echo || i_cmd.load_char || i_cmd.load_end) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Line store: written at the fill position, read one entry ahead of the drain.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && has_room) begin
            r_line[r_fill[IDX_W-1:0]] <= r_byte;
        end
        r_rd_data <= r_line[n_rd_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_rx_byte;
        end
        if (i_cmd.load_echo) begin
            r_kind <= KIND_ECHO;
            r_data <= r_byte;
            r_last <= !term;
        end else if (i_cmd.load_char) begin
            r_kind <= KIND_CHAR;
            r_data <= r_rd_data;
            r_last <= 1'b0;
        end else if (i_cmd.load_end) begin
            r_kind <= KIND_END;
            r_data <= '0;
            r_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_kind;
    assign o_out_data  = r_data;
    assign o_out_last  = r_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(LINE_DEPTH))
        else $error("fill count beyond line depth");

    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_idx <= r_fill)
        else $error("drain index passed fill count");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_end |=> (r_fill == '0) && (r_rd_idx == '0))
        else $error("end of message did not clear the line");

    a_end_format: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == KIND_END)) |-> (r_last && (r_data == '0)))
        else $error("malformed end-of-message item");

endmodule

`default_nettype wire

FILE: rtl/core/sla_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sla_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire sla_pkg::t_status i_status,
    output sla_pkg::t_cmd         o_cmd
);
    import sla_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_ECHO;
                end
            end
            ST_ECHO: begin
                if (i_status.out_free) begin
                    n_state = i_status.term ? ST_DRAIN : ST_IDLE;
                end
            end
            ST_DRAIN: begin
                if (i_status.out_free && i_status.drain_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_ECHO: begin
                if (i_status.out_free) begin
                    o_cmd.load_echo = 1'b1;
                    o_cmd.append    = !i_status.term;
                end
            end
            ST_DRAIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_end  = i_status.drain_done;
                    o_cmd.load_char = !i_status.drain_done;
                end
            end
            default: o_cmd = '0;
        endcase
    end

    a_one_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_echo, o_cmd.load_char, o_cmd.load_end}))
        else $error("more than one output load in a cycle");

    a_echo_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_ECHO))
        else $error("accepted item not followed by its echo");

    a_drain_after_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_echo && i_status.term) |=> (r_state == ST_DRAIN))
        else $error("line end did not start the drain");

endmodule

`default_nettype wire

FILE: rtl/core/serial_line_assembler_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial line assembler. Each input item is one received byte; the block
// echoes it at once as a byte-echo item (kind 0). A carriage return or a line
// feed ends the line: after the echo, the stored characters come out in order
// as message-character items (kind 1), then an end-of-message item (kind 2,
// data 0, last set), and the line is emptied. Any other byte is kept while
// fewer than CAPACITY-1 characters are held and is dropped otherwise, which
// truncates the line. The last flag marks the final item caused by each
// input byte. The block works on one input byte at a time: it accepts no
// new byte until the echo of an ordinary byte, or the whole drain of a
// line, has been loaded into the output register, and a stalled output
// holds it back. The drain reads the line store one entry per cycle while
// the output side does not stall. The line store needs no clearing after
// reset.

module serial_line_assembler_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sla_in_if.sink     i_in,
    sla_out_if.source  o_out
);
    import sla_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    // Controller: sequences echo, append and line drain.
    sla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Datapath: captured byte, line store, fill count and the output register.
    sla_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_rx_byte   (i_in.rx_byte),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_kind  (o_out.kind),
        .o_out_data  (o_out.data),
        .o_out_last  (o_out.last)
    );

    assign i_in.ready = in_ready;

endmodule

`default_nettype wire
